/* sv/msf_pkg.sv */
// Shared constants for the maximal square finder.
`default_nettype none
package msf_pkg;
    localparam int MAX_COLS_DEF = 1024;
    localparam int MAX_ROWS_DEF = 1024;

    localparam int CFG_W  = 11;
    localparam int SIZE_W = 11;
    localparam int POS_W  = 10;

    localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

    typedef enum logic [0:0] {
        REG_NUM_COLS = 1'b0,
        REG_NUM_ROWS = 1'b1
    } t_reg_idx;
endpackage
`default_nettype wire

/* sv/maximal_square_finder_core.sv */
// Maximal square finder: raster DP over a map with a one-row line buffer.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-------------------------------------
//  in      | input     | i_in_valid / o_in_ready  | i_cell_free
//  out     | output    | o_out_valid / i_out_ready| o_cell_size, o_best_size, o_best_row,
//          |           |                          | o_best_col, o_map_done
//  cfg     | input     | i_cfg_we                 | i_cfg_addr, i_cfg_data
//
// One item per cycle sustained while the result register is not held; a result is
// valid after the input register (line-buffer read), then the result register.
// The line buffer is one RAM, read at acceptance and written one stage later.
// Reset clears counters, best tracking and valids; the line buffer is not cleared.
// When the result register is held, the stage behind it fills and then input stalls.
`default_nettype none
module maximal_square_finder_core #(
    parameter int MAX_COLS = msf_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = msf_pkg::MAX_ROWS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,

    input  wire logic                       i_cfg_we,
    input  wire logic                       i_cfg_addr,
    input  wire logic [msf_pkg::CFG_W-1:0]  i_cfg_data,

    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic                       i_cell_free,

    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic [msf_pkg::SIZE_W-1:0]      o_cell_size,
    output logic [msf_pkg::SIZE_W-1:0]      o_best_size,
    output logic [msf_pkg::POS_W-1:0]       o_best_row,
    output logic [msf_pkg::POS_W-1:0]       o_best_col,
    output logic                            o_map_done
);
    localparam int CW   = $clog2(MAX_COLS);
    localparam int RW   = $clog2(MAX_ROWS);
    localparam int CC_W = $clog2(MAX_COLS + 1);
    localparam int RC_W = $clog2(MAX_ROWS + 1);
    localparam int SW   = msf_pkg::SIZE_W;

    // configuration
    logic [msf_pkg::CFG_W-1:0] r_num_cols;
    logic [msf_pkg::CFG_W-1:0] r_num_rows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_cols <= msf_pkg::CFG_W'(1024);
            r_num_rows <= msf_pkg::CFG_W'(1024);
        end else if (i_cfg_we) begin
            case (msf_pkg::t_reg_idx'(i_cfg_addr))
                msf_pkg::REG_NUM_COLS: r_num_cols <= i_cfg_data;
                msf_pkg::REG_NUM_ROWS: r_num_rows <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage 0: position tracking and line-buffer read
    logic [CW-1:0]   r_col_pos;
    logic [RW-1:0]   r_row_pos;
    logic [CC_W-1:0] n_cols;
    logic [RC_W-1:0] n_rows;
    logic [CW-1:0]   n_col;
    logic [RW-1:0]   n_row;
    logic            n_last_col;
    logic            n_last_row;
    logic            in_acc;

    always_comb begin
        if (r_num_cols == '0) begin
            n_cols = CC_W'(1);
        end else if (32'(r_num_cols) > MAX_COLS) begin
            n_cols = CC_W'(MAX_COLS);
        end else begin
            n_cols = CC_W'(r_num_cols);
        end
        if (r_num_rows == '0) begin
            n_rows = RC_W'(1);
        end else if (32'(r_num_rows) > MAX_ROWS) begin
            n_rows = RC_W'(MAX_ROWS);
        end else begin
            n_rows = RC_W'(r_num_rows);
        end
        n_col = (CC_W'(r_col_pos) < n_cols) ? r_col_pos : CW'(n_cols - CC_W'(1));
        n_row = (RC_W'(r_row_pos) < n_rows) ? r_row_pos : RW'(n_rows - RC_W'(1));
        n_last_col = (CC_W'(n_col) == n_cols - CC_W'(1));
        n_last_row = (RC_W'(n_row) == n_rows - RC_W'(1));
    end

    assign in_acc = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_pos <= '0;
            r_row_pos <= '0;
        end else if (in_acc) begin
            if (n_last_col && n_last_row) begin
                r_col_pos <= '0;
                r_row_pos <= '0;
            end else if (n_last_col) begin
                r_col_pos <= '0;
                r_row_pos <= n_row + RW'(1);
            end else begin
                r_col_pos <= n_col + CW'(1);
                r_row_pos <= n_row;
            end
        end
    end

    // line buffer
    logic [SW-1:0] r_line_buf [MAX_COLS];
    logic [SW-1:0] r_up;

    // stage 1: size update
    logic          r_s1_valid;
    logic          r_s1_free;
    logic          r_s1_edge;
    logic          r_s1_done;
    logic [CW-1:0] r_s1_col;
    logic [RW-1:0] r_s1_row;
    logic [SW-1:0] r_left;
    logic [SW-1:0] r_diag;
    logic [SW-1:0] r_best;
    logic [CW-1:0] r_best_col;
    logic [RW-1:0] r_best_row;
    logic [SW-1:0] n_min;
    logic [SW-1:0] n_size;
    logic          n_better;
    logic          s1_adv;

    assign s1_adv     = r_s1_valid && (!o_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;

    always_comb begin
        n_min = (r_left < r_up) ? r_left : r_up;
        n_min = (n_min < r_diag) ? n_min : r_diag;
        if (!r_s1_free) begin
            n_size = '0;
        end else if (r_s1_edge) begin
            n_size = SW'(1);
        end else if (n_min == msf_pkg::SIZE_MAX) begin
            n_size = msf_pkg::SIZE_MAX;
        end else begin
            n_size = n_min + SW'(1);
        end
        n_better = n_size > r_best;
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_up <= r_line_buf[n_col];
        end
        if (s1_adv) begin
            r_line_buf[r_s1_col] <= n_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_free <= i_cell_free;
            r_s1_edge <= (n_col == '0) || (n_row == '0);
            r_s1_done <= n_last_col && n_last_row;
            r_s1_col  <= n_col;
            r_s1_row  <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_left     <= '0;
            r_diag     <= '0;
            r_best     <= '0;
            r_best_col <= '0;
            r_best_row <= '0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                if (r_s1_done) begin
                    r_left     <= '0;
                    r_diag     <= '0;
                    r_best     <= '0;
                    r_best_col <= '0;
                    r_best_row <= '0;
                end else begin
                    r_left <= n_size;
                    r_diag <= r_up;
                    if (n_better) begin
                        r_best     <= n_size;
                        r_best_col <= r_s1_col;
                        r_best_row <= r_s1_row;
                    end
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (s1_adv) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            o_cell_size <= n_size;
            o_map_done  <= r_s1_done;
            if (n_better) begin
                o_best_size <= n_size;
                o_best_row  <= msf_pkg::POS_W'(r_s1_row);
                o_best_col  <= msf_pkg::POS_W'(r_s1_col);
            end else begin
                o_best_size <= r_best;
                o_best_row  <= msf_pkg::POS_W'(r_best_row);
                o_best_col  <= msf_pkg::POS_W'(r_best_col);
            end
        end
    end
endmodule
`default_nettype wire
